### src/swer_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package swer_pkg;

  localparam int TIME_BITS  = 40;
  localparam int RING_DEPTH = 1024;
  localparam int SLOT_BITS  = $clog2(RING_DEPTH);
  localparam int HELD_BITS  = $clog2(RING_DEPTH + 1);
  localparam int WIN_BITS   = 17;
  localparam int COUNT_BITS = 10;
  localparam int FRAC_BITS  = 16;
  localparam int RATE_BITS  = COUNT_BITS + FRAC_BITS;
  localparam int DIV_CNT_BITS = $clog2(RATE_BITS + 1);

  localparam logic [WIN_BITS-1:0]   WIN_RESET = WIN_BITS'(1800);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [SLOT_BITS-1:0]  slot_t;
  typedef logic [HELD_BITS-1:0]  held_t;
  typedef logic [WIN_BITS-1:0]   win_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [RATE_BITS-1:0]  rate_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_LOAD,
    ST_CHECK,
    ST_DIVIDE,
    ST_DONE
  } swer_state_t;

  function automatic slot_t next_slot(input slot_t s);
    return (s == SLOT_BITS'(RING_DEPTH - 1)) ? '0 : s + slot_t'(1);
  endfunction

endpackage
`default_nettype wire

### src/swer_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface swer_in_if import swer_pkg::*; ();
  logic  valid;
  logic  ready;
  time_t event_time;
  logic  starts_series;

  modport source (output valid, output event_time, output starts_series, input ready);
  modport sink   (input valid, input event_time, input starts_series, output ready);
endinterface

interface swer_out_if import swer_pkg::*; ();
  logic   valid;
  logic   ready;
  time_t  stamp;
  count_t event_count;
  time_t  elapsed_seconds;
  rate_t  rate_q16;
  logic   overflowed;

  modport source (output valid, output stamp, output event_count, output elapsed_seconds,
                  output rate_q16, output overflowed, input ready);
  modport sink   (input valid, input stamp, input event_count, input elapsed_seconds,
                  input rate_q16, input overflowed, output ready);
endinterface

interface swer_cfg_if import swer_pkg::*; ();
  logic valid;
  logic ready;
  win_t window_seconds;

  modport source (output valid, output window_seconds, input ready);
  modport sink   (input valid, input window_seconds, output ready);
endinterface
`default_nettype wire

### src/sliding_window_event_rate.sv
`timescale 1ns / 1ps
`default_nettype none
// Sliding-window event rate. Each item is a timestamp in seconds; the block keeps
// recent timestamps in a 1024-entry ring memory (one read, one write port) and, per
// item, drops held events older than window_seconds before the newest (always keeping
// the one before it), then reports count, span and count/span in Q10.16 through a
// bit-serial restoring divider. One subtractor serves both the ring age check and the
// divider trial step. An item is accepted while idle and then stored; a series start
// ends there. Otherwise the oldest held entry is read and compared, once more per
// evicted entry (each eviction is one ring read and compare), and when a result is
// produced the divider gives 26 quotient bits, one per cycle, then the output load.
// in ready is high only while the sequencer is idle; a result waits in the output
// register without blocking the next item, but the output load of the next result
// waits until the earlier one is taken. The window register may be written at any
// time the block is idle; cfg ready is always high.
module sliding_window_event_rate
  import swer_pkg::*;
(
  input  wire             clk,
  input  wire             rst_n,
  swer_in_if.sink         in_item,
  swer_out_if.source      out_item,
  swer_cfg_if.sink        cfg_wr
);

  swer_state_t state_r, state_nxt;

  time_t  ring_mem [RING_DEPTH];
  time_t  rd_data_r;
  logic   wr_en;
  slot_t  wr_addr;

  slot_t  oldest_r, oldest_nxt;
  slot_t  newest_r, newest_nxt;
  held_t  held_r, held_nxt;
  win_t   window_r;

  time_t  t_r, t_nxt;
  logic   restart_r, restart_nxt;
  logic   forced_r, forced_nxt;
  time_t  elapsed_r, elapsed_nxt;
  rate_t  num_r, num_nxt;
  rate_t  rem_r, rem_nxt;
  logic [DIV_CNT_BITS-1:0] div_cnt_r, div_cnt_nxt;

  logic   out_valid_r, out_valid_nxt;
  time_t  out_stamp_r;
  count_t out_count_r;
  time_t  out_elapsed_r;
  rate_t  out_rate_r;
  logic   out_flag_r;
  logic   out_load;

  logic   div_step;
  time_t  sub_a;
  time_t  sub_b;
  logic [TIME_BITS:0] diff;
  logic   borrow;
  time_t  age;
  logic   too_old;
  logic   not_later;
  logic [RATE_BITS:0] trial;
  logic   trial_fits;
  held_t  count_full;
  count_t count_sat;

  assign in_item.ready = (state_r == ST_IDLE);
  assign cfg_wr.ready  = 1'b1;

  // shared subtract/compare: ring age check, then divider trial step
  assign trial    = {rem_r, num_r[RATE_BITS-1]};
  assign div_step = (state_r == ST_DIVIDE);
  assign sub_a    = div_step ? TIME_BITS'(trial) : t_r;
  assign sub_b    = div_step ? elapsed_r : rd_data_r;
  assign diff     = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow   = diff[TIME_BITS];
  assign age      = diff[TIME_BITS-1:0];

  assign too_old    = !borrow && (age > TIME_BITS'(window_r));
  assign not_later  = borrow || (age == '0);
  assign trial_fits = !borrow;

  assign count_full = held_r - held_t'(1);
  assign count_sat  = (count_full > HELD_BITS'(COUNT_MAX)) ? COUNT_MAX
                                                          : COUNT_BITS'(count_full);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= t_r;
    end
    rd_data_r <= ring_mem[oldest_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      oldest_r    <= '0;
      newest_r    <= '0;
      held_r      <= '0;
      window_r    <= WIN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      newest_r    <= newest_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr.valid) begin
        window_r <= cfg_wr.window_seconds;
      end
    end
  end

  always_ff @(posedge clk) begin
    t_r       <= t_nxt;
    restart_r <= restart_nxt;
    forced_r  <= forced_nxt;
    elapsed_r <= elapsed_nxt;
    num_r     <= num_nxt;
    rem_r     <= rem_nxt;
    div_cnt_r <= div_cnt_nxt;
    if (out_load) begin
      out_stamp_r   <= t_r;
      out_count_r   <= count_sat;
      out_elapsed_r <= elapsed_r;
      out_rate_r    <= num_r;
      out_flag_r    <= forced_r;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    oldest_nxt  = oldest_r;
    newest_nxt  = newest_r;
    held_nxt    = held_r;
    t_nxt       = t_r;
    restart_nxt = restart_r;
    forced_nxt  = forced_r;
    elapsed_nxt = elapsed_r;
    num_nxt     = num_r;
    rem_nxt     = rem_r;
    div_cnt_nxt = div_cnt_r;
    wr_en       = 1'b0;
    wr_addr     = next_slot(newest_r);
    out_load    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_item.valid) begin
          t_nxt       = in_item.event_time;
          restart_nxt = in_item.starts_series;
          state_nxt   = ST_STORE;
        end
      end
      ST_STORE: begin
        wr_en = 1'b1;
        if (restart_r || held_r == '0) begin
          wr_addr    = '0;
          oldest_nxt = '0;
          newest_nxt = '0;
          held_nxt   = held_t'(1);
          state_nxt  = ST_IDLE;
        end else begin
          // full ring: the oldest entry makes room for the new one
          if (held_r >= HELD_BITS'(RING_DEPTH)) begin
            oldest_nxt = next_slot(oldest_r);
            forced_nxt = 1'b1;
          end else begin
            held_nxt   = held_r + held_t'(1);
            forced_nxt = 1'b0;
          end
          newest_nxt = next_slot(newest_r);
          state_nxt  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (held_r > held_t'(2) && too_old) begin
          oldest_nxt = next_slot(oldest_r);
          held_nxt   = held_r - held_t'(1);
          state_nxt  = ST_LOAD;
        end else if (not_later) begin
          state_nxt = ST_IDLE;
        end else begin
          elapsed_nxt = age;
          num_nxt     = {count_sat, FRAC_BITS'(0)};
          rem_nxt     = '0;
          div_cnt_nxt = DIV_CNT_BITS'(RATE_BITS);
          state_nxt   = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        // remainder stays below both divisor and 2**RATE_BITS
        rem_nxt     = trial_fits ? RATE_BITS'(age) : RATE_BITS'(trial);
        num_nxt     = {num_r[RATE_BITS-2:0], trial_fits};
        div_cnt_nxt = div_cnt_r - DIV_CNT_BITS'(1);
        if (div_cnt_r == DIV_CNT_BITS'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_item.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_item.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_item.valid           = out_valid_r;
  assign out_item.stamp           = out_stamp_r;
  assign out_item.event_count     = out_count_r;
  assign out_item.elapsed_seconds = out_elapsed_r;
  assign out_item.rate_q16        = out_rate_r;
  assign out_item.overflowed      = out_flag_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= HELD_BITS'(RING_DEPTH))
    else $error("held count beyond ring depth");

  a_check_two_held: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHECK |-> held_r >= held_t'(2))
    else $error("age check with fewer than two held events");

  a_divisor_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVIDE) |=> (state_r != ST_DIVIDE) || $stable(elapsed_r))
    else $error("divisor changed during division");

  a_span_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.valid |-> out_item.elapsed_seconds != '0)
    else $error("result with zero span");

endmodule
`default_nettype wire

### verif/sliding_window_event_rate_tb.sv
`timescale 1ns / 1ps
module sliding_window_event_rate_tb;
  import swer_pkg::*;

  localparam time_t TIME_MAX       = '1;
  localparam rate_t RATE_TOP       = '1;
  localparam win_t  WIN_TOP        = '1;
  // worst item: full ring walk plus the divide
  localparam int    SETTLE_CYCLES  = 2200;
  localparam int    WATCHDOG_LIMIT = 20000;

  typedef struct {
    time_t  stamp;
    count_t event_count;
    time_t  elapsed_seconds;
    rate_t  rate_q16;
    logic   overflowed;
  } rate_result_t;

  class rate_scoreboard;
    time_t        ring [RING_DEPTH];
    int unsigned  oldest;
    int unsigned  newest;
    int unsigned  held;
    win_t         window;
    rate_result_t pending_q [$];
    int unsigned  errors;
    int unsigned  items;
    int unsigned  series;
    int unsigned  results;
    int unsigned  full_results;

    function new();
      oldest = 0;
      newest = 0;
      held = 0;
      window = WIN_RESET;
      errors = 0;
      items = 0;
      series = 0;
      results = 0;
      full_results = 0;
    endfunction

    function void set_window(win_t w);
      window = w;
    endfunction

    function int unsigned outstanding();
      return pending_q.size();
    endfunction

    function void note_input(time_t t, logic starts);
      logic [63:0]  span;
      logic [63:0]  cnt;
      logic [63:0]  quot;
      logic         forced;
      rate_result_t exp;
      items++;
      if (starts || held == 0) begin
        oldest = 0;
        newest = 0;
        ring[0] = t;
        held = 1;
        series++;
        return;
      end
      forced = 1'b0;
      if (held >= RING_DEPTH) begin
        oldest = (oldest + 1) % RING_DEPTH;
        held--;
        forced = 1'b1;
      end
      newest = (newest + 1) % RING_DEPTH;
      ring[newest] = t;
      held++;
      // age out, but never below the newest and the one before it
      while (held > 2 && t >= ring[oldest] && (t - ring[oldest]) > window) begin
        oldest = (oldest + 1) % RING_DEPTH;
        held--;
      end
      // zero span or out-of-order timestamp: no item out
      if (t <= ring[oldest]) return;
      span = 64'(t) - 64'(ring[oldest]);
      cnt  = 64'(held - 1);
      quot = (cnt << FRAC_BITS) / span;
      exp.stamp           = t;
      exp.event_count     = (cnt > COUNT_MAX) ? COUNT_MAX : count_t'(cnt);
      exp.elapsed_seconds = time_t'(span);
      exp.rate_q16        = (quot > RATE_TOP) ? RATE_TOP : rate_t'(quot);
      exp.overflowed      = forced;
      pending_q.insert(pending_q.size(), exp);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(rate_result_t got);
      rate_result_t exp;
      if (pending_q.size() == 0) begin
        $error("unexpected item out: stamp %0d with nothing pending", got.stamp);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      results++;
      if (exp.overflowed) full_results++;
      compare_field("stamp", exp.stamp, got.stamp);
      compare_field("event_count", exp.event_count, got.event_count);
      compare_field("elapsed_seconds", exp.elapsed_seconds, got.elapsed_seconds);
      compare_field("rate_q16", exp.rate_q16, got.rate_q16);
      compare_field("overflowed", exp.overflowed, got.overflowed);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  swer_in_if  in_if ();
  swer_out_if out_if ();
  swer_cfg_if cfg_if ();

  rate_scoreboard sb = new();

  int burst_left = 0;
  int rx_left = 0;
  int idle_cycles = 0;
  int windows_written = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sliding_window_event_rate dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_if),
    .out_item (out_if),
    .cfg_wr   (cfg_if)
  );

  // output monitor and receiver stall pattern
  always @(posedge clk) begin
    rate_result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.stamp           = out_if.stamp;
      got.event_count     = out_if.event_count;
      got.elapsed_seconds = out_if.elapsed_seconds;
      got.rate_q16        = out_if.rate_q16;
      got.overflowed      = out_if.overflowed;
      sb.check_result(got);
    end
    if (rx_left == 0) begin
      case ($urandom_range(0, 7))
        0: begin
          out_if.ready <= 1'b1;
          rx_left = $urandom_range(100, 400);
        end
        1, 2, 3: begin
          out_if.ready <= 1'b1;
          rx_left = $urandom_range(1, 40);
        end
        default: begin
          out_if.ready <= 1'b0;
          rx_left = $urandom_range(1, 30);
        end
      endcase
    end else begin
      rx_left = rx_left - 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  // sender: bursts of random length, random gaps between bursts
  task automatic feed_item(input time_t t, input logic starts);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 70);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid         <= 1'b1;
    in_if.event_time    <= t;
    in_if.starts_series <= starts;
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(t, starts);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // window changes only with the block idle: drain, let a silent item finish, write
  task automatic retune_window(input win_t w);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_if.valid          <= 1'b1;
    cfg_if.window_seconds <= w;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.set_window(w);
    windows_written++;
    burst_left = 0;
  endtask

  task automatic run_random_phase(input int n_items);
    int          done;
    int          series_left;
    logic [63:0] inc;
    time_t       t;
    done = 0;
    t = '0;
    while (done < n_items) begin
      case ($urandom_range(0, 3))
        0: t = time_t'($urandom_range(0, 100));
        1: t = TIME_MAX - time_t'($urandom_range(0, 5000));
        default: t = time_t'({$urandom, $urandom});
      endcase
      // mostly a clean series start; sometimes a jump without one
      feed_item(t, $urandom_range(0, 7) != 0);
      done++;
      series_left = $urandom_range(1, 60);
      while (series_left > 0 && done < n_items) begin
        case ($urandom_range(0, 19))
          0: feed_item(t - time_t'($urandom_range(1, 3000)), 1'b0);
          1: feed_item(time_t'({$urandom, $urandom}), 1'b0);
          2: feed_item(t, 1'b1);
          default: begin
            case ($urandom_range(0, 9))
              0, 1: inc = '0;
              2, 3, 4, 5: inc = $urandom_range(0, sb.window / 8 + 1);
              6, 7, 8: inc = $urandom_range(0, 2 * sb.window + 2);
              default: inc = {$urandom, $urandom} >> $urandom_range(8, 63);
            endcase
            t = t + time_t'(inc);
            feed_item(t, 1'b0);
          end
        endcase
        done++;
        series_left--;
        if ($urandom_range(0, 59) == 0) drain_results();
      end
    end
  endtask

  initial begin
    time_t t;
    in_if.valid           = 1'b0;
    in_if.event_time      = '0;
    in_if.starts_series   = 1'b0;
    out_if.ready          = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.window_seconds = WIN_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default window: first item after reset, zero span, exact edge of the window,
    // out-of-order stamp, top of the time range
    feed_item('0, 1'b0);
    feed_item('0, 1'b0);
    feed_item(time_t'(1), 1'b0);
    feed_item(time_t'(1801), 1'b0);
    feed_item(time_t'(3601), 1'b0);
    feed_item(time_t'(5), 1'b0);
    feed_item(TIME_MAX, 1'b1);
    feed_item(TIME_MAX, 1'b0);
    feed_item(TIME_MAX - 2, 1'b1);
    feed_item(TIME_MAX, 1'b0);
    feed_item(TIME_MAX - 1, 1'b0);

    // zero window drops everything older except the previous event
    retune_window('0);
    feed_item(time_t'(1000), 1'b1);
    feed_item(time_t'(1000), 1'b0);
    feed_item(time_t'(1000), 1'b0);
    feed_item(time_t'(1001), 1'b0);
    feed_item(time_t'(1001), 1'b0);
    feed_item(time_t'(1005), 1'b0);
    feed_item(time_t'(999), 1'b0);

    retune_window(WIN_TOP);
    run_random_phase(80);
    retune_window(win_t'(1));
    run_random_phase(80);
    retune_window(win_t'(86400));
    run_random_phase(80);
    retune_window(win_t'($urandom_range(2, 5000)));
    run_random_phase(80);
    retune_window(win_t'($urandom));
    run_random_phase(80);

    // one long series, then one jump that walks nearly all of it out
    retune_window(WIN_TOP);
    t = time_t'({$urandom, $urandom}) >> 1;
    feed_item(t, 1'b1);
    for (int k = 0; k < 300; k++) begin
      t = t + time_t'($urandom_range(0, 1));
      feed_item(t, 1'b0);
      if ($urandom_range(0, 199) == 0) drain_results();
    end
    t = t + time_t'(WIN_TOP) + time_t'($urandom_range(1, 1000));
    feed_item(t, 1'b0);
    for (int k = 0; k < 10; k++) begin
      t = t + time_t'($urandom_range(0, 3));
      feed_item(t, 1'b0);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d items in %0d series under %0d window settings",
             sb.items, sb.series, windows_written + 1);
    $display("Checked %0d rate items, %0d of them with the ring forced",
             sb.results, sb.full_results);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
